### rtl/core/bounding_sphere_grow_assert.svh
// Assertion macros for the bounding sphere grow checker.
`ifndef BOUNDING_SPHERE_GROW_ASSERT_SVH
`define BOUNDING_SPHERE_GROW_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define BSG_AST_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define BSG_AST_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/bsg_pkg.sv
// Shared types and widths for the bounding sphere grow block.
package bsg_pkg;
  localparam int MagW  = 33;  // |item - centre| per axis
  localparam int OpW   = 34;  // multiplier operand width
  localparam int ProdW = 68;  // product / radicand width
  localparam int QW    = 33;  // quotient width

  typedef enum logic {AX_SQ, AX_MV} ax_mode_t;

  typedef struct packed {
    logic     go;
    ax_mode_t mode;
  } ax_ctl_t;
endpackage

### rtl/core/bounding_sphere_grow.sv
// Top level: incremental 3-D bounding sphere with bit-serial arithmetic.
//
//  port group   dir  transfer content
//  s_*          in   one item sphere: centre, radius, start flag
//  m_*          out  bound sphere after the update, one per item
//
// Start item: loaded as the kept sphere on accept, then presented from the finish state.
// Merge item: the squares (three axis units in parallel), the sqrt steps, the decide,
// the multiply, then a load and the divide for the move; the result is committed
// and presented from the finish state. Only one item is in flight at a time.
// Enclosed, replacing or coincident items end after the decide.
// The result sits in an output register; the next item is taken while it waits.
// rst (synchronous) clears the sphere to a zero-radius point at the origin.
module bounding_sphere_grow
  import bsg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // in_x, in_y, in_z, in_radius
  input  logic         s_tuser,   // start_new
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // out_x, out_y, out_z, out_radius
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_SQR, ST_ROOT, ST_DECIDE, ST_MOVE, ST_FINISH
  } state_t;

  state_t state;

  // kept sphere
  logic signed [31:0] cx, cy, cz;
  logic [31:0]        rad;

  // current item
  logic [31:0]      ix, iy, iz, ir;
  logic [2:0]       sgn;
  logic [MagW-1:0]  mag [3];
  logic [MagW-1:0]  mag_in [3];
  logic [2:0]       sgn_in;
  logic [MagW-1:0]  diff [3];

  ax_ctl_t          ctl;
  logic             ax_go;
  ax_mode_t         ax_mode;
  logic [ProdW-1:0] prod [3];
  logic [QW-1:0]    quot [3];
  logic [2:0]       ax_done;

  // sqrt: two radicand bits per step
  logic [ProdW-1:0] rsh;
  logic [OpW+1:0]   srem;
  logic [OpW-1:0]   root;
  logic [5:0]       cnt;
  logic [OpW+1:0]   t_rem;
  logic [OpW+1:0]   trial;
  logic             s_ge;

  // decision
  logic [OpW:0]   sum_rd, sum_Rd;
  logic [OpW+1:0] full_sum;
  logic [OpW:0]   full_w;
  logic [OpW:0]   k_w;
  logic [OpW:0]   full;
  logic [OpW-1:0] kreg;
  logic           do_move;

  logic [32:0] nx, ny, nz;

  assign s_tready = (state == ST_IDLE);

  // offsets taken straight from the incoming transfer
  always_comb begin
    diff[0] = {s_tdata[31], s_tdata[31:0]}   - {cx[31], cx};
    diff[1] = {s_tdata[63], s_tdata[63:32]}  - {cy[31], cy};
    diff[2] = {s_tdata[95], s_tdata[95:64]}  - {cz[31], cz};
    for (int a = 0; a < 3; a++) begin
      sgn_in[a] = diff[a][32];
      mag_in[a] = diff[a][32] ? MagW'(-diff[a]) : diff[a];
    end
  end

  assign t_rem = {srem[OpW-1:0], rsh[ProdW-1:ProdW-2]};
  assign trial = {root, 2'b01};
  assign s_ge  = t_rem >= trial;

  assign sum_rd   = {3'b000, ir}  + {1'b0, root};
  assign sum_Rd   = {3'b000, rad} + {1'b0, root};
  assign full_sum = {4'b0000, rad} + {4'b0000, ir} + {2'b00, root};
  assign full_w   = full_sum[OpW+1:1];
  assign k_w      = full_w - {3'b000, rad};

  // merge needed: no enclosure either way and distinct centres
  assign do_move = !({3'b000, rad} > sum_rd) && !({3'b000, ir} > sum_Rd) &&
                   (root != '0);

  assign nx = sgn[0] ? {cx[31], cx} - quot[0] : {cx[31], cx} + quot[0];
  assign ny = sgn[1] ? {cy[31], cy} - quot[1] : {cy[31], cy} + quot[1];
  assign nz = sgn[2] ? {cz[31], cz} - quot[2] : {cz[31], cz} + quot[2];

  assign ctl = '{go: ax_go, mode: ax_mode};

  for (genvar a = 0; a < 3; a++) begin : g_ax
    bsg_axis u_ax (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .mag  (mag[a]),
      .k    (kreg),
      .d    (root),
      .prod (prod[a]),
      .quot (quot[a]),
      .done (ax_done[a])
    );
  end

  // one-cycle start pulse for the axis units
  always_ff @(posedge clk) begin
    if (rst) begin
      ax_go <= 1'b0;
    end else begin
      ax_go <= (state == ST_IDLE && s_tvalid && !s_tuser) ||
               (state == ST_DECIDE && do_move);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      ax_mode  <= AX_SQ;
      cx       <= '0;
      cy       <= '0;
      cz       <= '0;
      rad      <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ix  <= s_tdata[31:0];
            iy  <= s_tdata[63:32];
            iz  <= s_tdata[95:64];
            ir  <= s_tdata[127:96];
            sgn <= sgn_in;
            mag <= mag_in;
            if (s_tuser) begin
              cx    <= s_tdata[31:0];
              cy    <= s_tdata[63:32];
              cz    <= s_tdata[95:64];
              rad   <= s_tdata[127:96];
              state <= ST_FINISH;
            end else begin
              ax_mode <= AX_SQ;
              state   <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (&ax_done) begin
            rsh   <= prod[0] + prod[1] + prod[2];
            srem  <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          srem <= s_ge ? t_rem - trial : t_rem;
          root <= {root[OpW-2:0], s_ge};
          rsh  <= {rsh[ProdW-3:0], 2'b00};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'(OpW-1)) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if ({3'b000, rad} > sum_rd) begin
            state <= ST_FINISH;                 // kept sphere encloses item
          end else if ({3'b000, ir} > sum_Rd) begin
            cx    <= ix;                         // item encloses kept sphere
            cy    <= iy;
            cz    <= iz;
            rad   <= ir;
            state <= ST_FINISH;
          end else if (root == '0) begin
            state <= ST_FINISH;                 // coincident centres
          end else begin
            full    <= full_w;
            kreg    <= k_w[OpW-1:0];
            ax_mode <= AX_MV;
            state   <= ST_MOVE;
          end
        end
        ST_MOVE: begin
          if (&ax_done) begin
            cx    <= nx[31:0];
            cy    <= ny[31:0];
            cz    <= nz[31:0];
            rad   <= (full[OpW:32] != '0) ? 32'hFFFF_FFFF : full[31:0];
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {rad, cz, cy, cx};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/bsg_axis.sv
// Per-axis shift-add multiplier and restoring divider, one bit per cycle.
module bsg_axis
  import bsg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ax_ctl_t          ctl,
  input  logic [MagW-1:0]  mag,
  input  logic [OpW-1:0]   k,
  input  logic [OpW-1:0]   d,
  output logic [ProdW-1:0] prod,
  output logic [QW-1:0]    quot,
  output logic             done
);
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} ax_state_t;

  ax_state_t        state;
  ax_mode_t         mode;
  logic [6:0]       cnt;
  logic [ProdW-1:0] ma;
  logic [OpW-1:0]   mb;
  logic [OpW:0]     rem;
  logic [OpW+1:0]   trem;
  logic             ge;

  assign trem = {rem, quot[QW-1]};
  assign ge   = trem >= {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ctl.go) begin
            mode  <= ctl.mode;
            ma    <= {{(ProdW-MagW){1'b0}}, mag};
            mb    <= (ctl.mode == AX_SQ) ? {1'b0, mag} : k;
            prod  <= '0;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mb[0]) prod <= prod + ma;
          ma  <= {ma[ProdW-2:0], 1'b0};
          mb  <= {1'b0, mb[OpW-1:1]};
          cnt <= cnt + 7'd1;
          if (cnt == 7'(OpW-1)) begin
            if (mode == AX_SQ) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // first cycle loads the dividend split across rem and quot
          if (cnt == 7'(OpW)) begin
            rem  <= prod[ProdW-1:QW];
            quot <= prod[QW-1:0];
          end else begin
            rem  <= ge ? (OpW+1)'(trem - {2'b00, d}) : trem[OpW:0];
            quot <= {quot[QW-2:0], ge};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'(OpW+QW)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/bsg_checker.sv
// Port-level checker for the bounding sphere grow block, with its bind.
`include "bounding_sphere_grow_assert.svh"

module bsg_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);
  `BSG_AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output dropped while stalled")
  `BSG_AST_NOW(a_rst_quiet, $past(rst), !m_tvalid, "result right after reset")
  `BSG_AST_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted two items back to back")
endmodule

bind bounding_sphere_grow bsg_checker u_bsg_checker (.*);

### tb/tb_bounding_sphere_grow.sv
// Testbench for bounding_sphere_grow: random and directed sphere streams checked against a local model.
module tb_bounding_sphere_grow;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        start;
    logic [31:0] r;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } sphere_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;

  bounding_sphere_grow u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // Model state of the kept bound, widened to hold intermediate values.
  logic signed [63:0] bound_cx, bound_cy, bound_cz;
  logic [63:0]        bound_r;

  sphere_item_t pending_spheres[$];
  logic [127:0] expected_bounds[$];
  int  send_idle_pct = 32, recv_idle_pct = 84;
  bit  hold_send = 1'b0;
  int  mismatches = 0, results_seen = 0;
  int  n_start = 0, n_merge = 0;

  function automatic logic [63:0] isqrt68(logic [67:0] radicand);
    logic [63:0]  root;
    logic [67:0]  trial;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = 68'(root | (64'd1 << b)) * 68'(root | (64'd1 << b));
      if (trial <= radicand) root = root | (64'd1 << b);
    end
    return root;
  endfunction

  // Moves one centre coordinate toward the item by |off|*k/d, truncated.
  function automatic logic signed [63:0] shift_axis(logic signed [63:0] c,
      logic signed [63:0] off, logic [63:0] k, logic [63:0] d);
    logic [127:0] mag, q;
    mag = (off < 0) ? 128'(-off) : 128'(off);
    q = (mag * 128'(k)) / 128'(d);
    return (off < 0) ? c - $signed(64'(q)) : c + $signed(64'(q));
  endfunction

  // Applies one item to the model bound and returns the packed bound.
  function automatic logic [127:0] grow_bound(sphere_item_t it);
    logic signed [63:0] ix, iy, iz, dx, dy, dz;
    logic [63:0] ir, d, full, k, mx, my, mz;
    logic [67:0] sum;
    ix = 64'($signed(it.x)); iy = 64'($signed(it.y)); iz = 64'($signed(it.z));
    ir = 64'(it.r);
    if (it.start) begin
      bound_cx = ix; bound_cy = iy; bound_cz = iz; bound_r = ir;
    end else begin
      dx = ix - bound_cx; dy = iy - bound_cy; dz = iz - bound_cz;
      mx = (dx < 0) ? 64'(-dx) : 64'(dx);
      my = (dy < 0) ? 64'(-dy) : 64'(dy);
      mz = (dz < 0) ? 64'(-dz) : 64'(dz);
      sum = 68'(mx) * 68'(mx) + 68'(my) * 68'(my) + 68'(mz) * 68'(mz);
      d = isqrt68(sum);
      if (bound_r > ir + d) begin
        // kept bound already covers the item
      end else if (ir > bound_r + d) begin
        bound_cx = ix; bound_cy = iy; bound_cz = iz; bound_r = ir;
      end else if (d != 0) begin
        full = (bound_r + ir + d) >> 1;
        k = full - bound_r;
        bound_cx = shift_axis(bound_cx, dx, k, d);
        bound_cy = shift_axis(bound_cy, dy, k, d);
        bound_cz = shift_axis(bound_cz, dz, k, d);
        bound_r = (full > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : full;
      end
    end
    return {bound_r[31:0], bound_cz[31:0], bound_cy[31:0], bound_cx[31:0]};
  endfunction

  // Driver: presents queued items, lowering valid only when nothing is sent.
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (pending_spheres.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          sphere_item_t it;
          it = pending_spheres.pop_front();
          s_tdata  <= {it.r, it.z, it.y, it.x};
          s_tuser  <= it.start;
          s_tvalid <= 1'b1;
          if (it.start) n_start++; else n_merge++;
          expected_bounds.push_back(grow_bound(it));
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and field-by-field comparison.
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_bounds.size() == 0) begin
          mismatches++;
          $display("%0t unexpected bound transfer %h", $realtime, m_tdata);
        end else begin
          want = expected_bounds.pop_front();
          for (int f = 0; f < 4; f++)
            if (want[f*32 +: 32] !== m_tdata[f*32 +: 32]) begin
              mismatches++;
              $display("%0t field %0d (x,y,z,radius) expected %h actual %h",
                       $realtime, f, want[f*32 +: 32], m_tdata[f*32 +: 32]);
            end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [31:0] rand_coord(int spread);
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return 32'($signed($urandom_range(2*spread)) - spread);
    endcase
  endfunction

  function automatic sphere_item_t make_item(bit st, logic [31:0] x, logic [31:0] y,
      logic [31:0] z, logic [31:0] r);
    sphere_item_t it;
    it.start = st; it.x = x; it.y = y; it.z = z; it.r = r;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_spheres.size() > 0 || s_tvalid || expected_bounds.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int spread;
    bound_cx = 0; bound_cy = 0; bound_cz = 0; bound_r = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Merge before any start: grows from the origin point.
    pending_spheres.push_back(make_item(0, 32'h0003_0000, 0, 0, 32'h0001_0000));
    pending_spheres.push_back(make_item(0, 0, 32'hFFFD_0000, 0, 0));
    // Coincident centres with equal radii: state kept.
    pending_spheres.push_back(make_item(1, 32'h0001_0000, 32'h0002_0000, 0, 32'h0004_0000));
    pending_spheres.push_back(make_item(0, 32'h0001_0000, 32'h0002_0000, 0, 32'h0004_0000));
    // Kept encloses item, item encloses kept.
    pending_spheres.push_back(make_item(0, 32'h0001_8000, 32'h0002_0000, 0, 32'h0000_1000));
    pending_spheres.push_back(make_item(0, 0, 0, 32'h0000_4000, 32'h0100_0000));
    // Extremes and radius saturation.
    pending_spheres.push_back(make_item(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'hFFFF_FFFF));
    pending_spheres.push_back(make_item(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'hFFFF_FFFF));
    pending_spheres.push_back(make_item(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    pending_spheres.push_back(make_item(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    pending_spheres.push_back(make_item(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    pending_spheres.push_back(make_item(1, 32'h0000_0001, 32'hFFFF_FFFF, 0, 32'h0000_0001));
    pending_spheres.push_back(make_item(0, 32'hFFFF_FFFF, 32'h0000_0001, 0, 32'h0000_0001));
    pending_spheres.push_back(make_item(0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                                        32'hAAAA_5555));
    wait_drained();

    // Hold the sender with an item queued, then release it.
    hold_send = 1'b1;
    pending_spheres.push_back(make_item(0, 32'h0010_0000, 32'h0020_0000, 0, 32'h0000_8000));
    repeat (20) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();

    // Three idling phases; 280 items each, with clustered coordinates of varying spread.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 32 : 0;
      for (int n = 0; n < 280; n++) begin
        spread = ($urandom_range(3) == 0) ? 32'h7FFF_FFFF : $urandom_range(32'h0100_0000, 16);
        pending_spheres.push_back(make_item(($urandom_range(11) == 0),
            rand_coord(spread), rand_coord(spread), rand_coord(spread),
            ($urandom_range(4) == 0) ? $urandom() :
            ($urandom_range(3) == 0) ? 32'h0 : 32'($urandom_range(spread))));
      end
      wait_drained();
    end
    repeat (200) @(posedge clk);

    $display("Covered %0d start items and %0d merges, %0d bounds compared.",
             n_start, n_merge, results_seen);
    if (mismatches == 0)
      $display("[bounding_sphere_grow] OK");
    else
      $display("[bounding_sphere_grow] ERROR");
    $finish;
  end

  // Watchdog: ~900 items, heavy stalls, with a wide margin.
  initial begin
    #(12ns * 2_000_000);
    $display("[bounding_sphere_grow] ERROR");
    $finish;
  end
endmodule
